// ----- rtl/wsf_pkg.sv -----
package wsf_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] CHUNK_RESET = 32'd125;

  localparam logic [7:0] HDR_FIN     = 8'h80;
  localparam logic [7:0] OP_TEXT     = 8'h01;
  localparam logic [7:0] OP_CONT     = 8'h00;
  localparam logic [7:0] LEN16_CODE  = 8'd126;
  localparam logic [7:0] LEN64_CODE  = 8'd127;
  localparam logic [31:0] LEN7_MAX   = 32'd125;
  localparam logic [31:0] LEN16_MAX  = 32'd65535;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] message_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_message;
  } out_item_t;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_SHORT,
    HDR_MID,
    HDR_LONG
  } hdr_kind_t;

  // One accepted byte as the back end needs it: the header form, the
  // header's first byte and the frame length it declares.
  typedef struct packed {
    hdr_kind_t   kind;
    logic [7:0]  h0;
    logic [31:0] flen;
    logic [7:0]  payload_byte;
    logic        eom;
  } job_t;

  function automatic logic [3:0] job_count(hdr_kind_t kind);
    logic [3:0] n;
    case (kind)
      HDR_NONE:  n = 4'd1;
      HDR_SHORT: n = 4'd3;
      HDR_MID:   n = 4'd5;
      HDR_LONG:  n = 4'd11;
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

  // Byte number idx of the output run for one job; the payload byte is last.
  function automatic logic [7:0] job_byte(job_t job, logic [3:0] idx);
    logic [7:0] b;
    b = job.payload_byte;
    if (idx == 4'd0 && job.kind != HDR_NONE) begin
      b = job.h0;
    end else begin
      case (job.kind)
        HDR_SHORT: begin
          if (idx == 4'd1) b = job.flen[7:0];
        end
        HDR_MID: begin
          case (idx)
            4'd1: b = LEN16_CODE;
            4'd2: b = job.flen[15:8];
            4'd3: b = job.flen[7:0];
            default: b = job.payload_byte;
          endcase
        end
        HDR_LONG: begin
          case (idx)
            4'd1: b = LEN64_CODE;
            4'd2, 4'd3, 4'd4, 4'd5: b = 8'd0;
            4'd6: b = job.flen[31:24];
            4'd7: b = job.flen[23:16];
            4'd8: b = job.flen[15:8];
            4'd9: b = job.flen[7:0];
            default: b = job.payload_byte;
          endcase
        end
        default: b = job.payload_byte;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- rtl/wsf_front.sv -----
module wsf_front #(
  parameter int LENGTH_BITS = wsf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  wsf_pkg::in_item_t item,
  input  logic [31:0]       frag_size,
  output logic              push,
  output wsf_pkg::job_t     job
);

  localparam int CW = LENGTH_BITS;

  logic [CW-1:0] message_offset, message_offset_next;
  logic [CW-1:0] frame_remaining, frame_remaining_next;
  logic          first_frame_flag, first_frame_flag_next;

  logic [63:0]   len64, flen64;
  logic [CW-1:0] len, rem, off_inc, fr_cur, fr_after, flen_cw;
  logic [31:0]   chunk, flen;
  logic          frame_start, final_frame, eom, len_zero;

  always_comb begin
    len64       = {32'd0, item.message_length};
    len         = len64[CW-1:0];
    len_zero    = (len == '0);
    chunk       = (frag_size == 32'd0) ? 32'd1 : frag_size;
    // An offset at or past a shrunk length opens a one-byte final frame.
    rem         = (message_offset < len) ? (len - message_offset) : CW'(1);
    final_frame = (64'(rem) <= 64'(chunk));
    flen        = final_frame ? 32'(rem) : chunk;
    flen64      = {32'd0, flen};
    flen_cw     = flen64[CW-1:0];
    frame_start = (frame_remaining == '0);
    fr_cur      = frame_start ? flen_cw : frame_remaining;
    fr_after    = fr_cur - CW'(1);
    off_inc     = message_offset + CW'(1);
    eom         = (off_inc >= len) || (message_offset >= len);

    job.h0 = (final_frame ? wsf_pkg::HDR_FIN : 8'h00) |
             (first_frame_flag ? wsf_pkg::OP_TEXT : wsf_pkg::OP_CONT);
    if (!frame_start) begin
      job.kind = wsf_pkg::HDR_NONE;
    end else if (flen <= wsf_pkg::LEN7_MAX) begin
      job.kind = wsf_pkg::HDR_SHORT;
    end else if (flen <= wsf_pkg::LEN16_MAX) begin
      job.kind = wsf_pkg::HDR_MID;
    end else begin
      job.kind = wsf_pkg::HDR_LONG;
    end
    job.flen         = flen;
    job.payload_byte = item.payload_byte;
    job.eom          = eom;
    push             = take && !len_zero;
  end

  always_comb begin
    message_offset_next   = message_offset;
    frame_remaining_next  = frame_remaining;
    first_frame_flag_next = first_frame_flag;
    if (push) begin
      if (eom) begin
        message_offset_next   = '0;
        frame_remaining_next  = '0;
        first_frame_flag_next = 1'b1;
      end else begin
        message_offset_next  = off_inc;
        frame_remaining_next = fr_after;
        if (fr_after == '0) first_frame_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_offset   <= '0;
      frame_remaining  <= '0;
      first_frame_flag <= 1'b1;
    end else begin
      message_offset   <= message_offset_next;
      frame_remaining  <= frame_remaining_next;
      first_frame_flag <= first_frame_flag_next;
    end
  end

endmodule

// ----- rtl/wsf_queue.sv -----
module wsf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wsf_pkg::job_t push_job,
  input  logic          pop,
  output logic          not_full,
  output logic          not_empty,
  output wsf_pkg::job_t head
);

  localparam int D  = wsf_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);
  localparam int NW = $clog2(D + 1);

  wsf_pkg::job_t slots [D];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign not_full  = (count != NW'(D));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + NW'(1);
      else if (pop && !push) count <= count - NW'(1);
    end
  end

endmodule

// ----- rtl/wsf_back.sv -----
module wsf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               have_job,
  input  wsf_pkg::job_t      job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output wsf_pkg::out_item_t out_data
);

  logic [3:0] idx, idx_next;
  logic       out_valid_next;
  logic       load, last;

  always_comb begin
    load = have_job && (!out_valid || out_ready);
    last = (idx == wsf_pkg::job_count(job.kind) - 4'd1);
    pop  = load && last;
    idx_next = idx;
    if (load) idx_next = last ? 4'd0 : idx + 4'd1;
    if (load)           out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte       <= wsf_pkg::job_byte(job, idx);
      out_data.last_of_run    <= last;
      out_data.end_of_message <= last && job.eom;
    end
  end

endmodule

// ----- rtl/websocket_fragment_framer.sv -----
// Channel  Dir  Payload          Handshake
// in       in   in_item_t        in_valid / in_ready
// out      out  out_item_t       out_valid / out_ready
// cfg      in   frag_size[31:0]  cfg_valid / cfg_ready (always ready)
//
// A request that continues a frame leaves as one byte; one that opens a frame
// leaves as 3, 5 or 11 bytes, header first. The back end emits one byte per
// cycle, back to back while out_ready stays high. A four-entry queue lets
// requests keep arriving while headers drain. Output is registered.
// in_ready falls only while the queue holds four requests.
// Reset is synchronous; the queue and the message state clear at once.
module websocket_fragment_framer #(
  parameter int LENGTH_BITS = wsf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wsf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wsf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  logic [31:0]   frag_size;
  logic          push, pop, not_full, not_empty;
  wsf_pkg::job_t push_job, head;

  assign cfg_ready = 1'b1;
  assign in_ready  = not_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_size <= wsf_pkg::CHUNK_RESET;
    end else if (cfg_valid) begin
      frag_size <= cfg_data;
    end
  end

  wsf_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (in_valid && in_ready),
    .item       (in_data),
    .frag_size  (frag_size),
    .push       (push),
    .job        (push_job)
  );

  wsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_full  (not_full),
    .not_empty (not_empty),
    .head      (head)
  );

  wsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .have_job  (not_empty),
    .job       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- bench/websocket_fragment_framer_test.sv -----
module websocket_fragment_framer_test;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 64;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  wsf_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  wsf_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = '0;

  wsf_pkg::in_item_t  pending_requests[$];
  wsf_pkg::out_item_t expected_bytes[$];

  int   requests_sent = 0;
  int   requests_taken = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   send_idle = 12;
  int   recv_idle = 61;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  // Framer state as the predictor sees it.
  logic [31:0] chunk_bytes = wsf_pkg::CHUNK_RESET;
  logic [31:0] msg_offset = '0;
  logic [31:0] frame_left = '0;
  logic        first_frame = 1'b1;

  websocket_fragment_framer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void expect_byte(logic [7:0] b, logic last, logic eom);
    wsf_pkg::out_item_t e;
    e.out_byte = b;
    e.last_of_run = last;
    e.end_of_message = eom;
    expected_bytes.push_back(e);
  endfunction

  // Works out the bytes one request produces and advances the framer state.
  function automatic void frame_request(wsf_pkg::in_item_t req);
    logic [31:0] len;
    logic [31:0] chunk;
    logic [31:0] rest;
    logic [31:0] flen;
    logic [31:0] next_off;
    logic [63:0] wide_len;
    logic        is_final;
    logic        eom;
    len = req.message_length;
    if (len == '0) return;
    if (frame_left == '0) begin
      chunk = (chunk_bytes == '0) ? 32'd1 : chunk_bytes;
      // When the length has shrunk to or below the offset, the frame carries one byte.
      rest = (msg_offset < len) ? len - msg_offset : 32'd1;
      is_final = rest <= chunk;
      flen = is_final ? rest : chunk;
      expect_byte((is_final ? wsf_pkg::HDR_FIN : '0) |
                  (first_frame ? wsf_pkg::OP_TEXT : wsf_pkg::OP_CONT), 1'b0, 1'b0);
      if (flen <= wsf_pkg::LEN7_MAX) begin
        expect_byte(flen[7:0], 1'b0, 1'b0);
      end else if (flen <= wsf_pkg::LEN16_MAX) begin
        expect_byte(wsf_pkg::LEN16_CODE, 1'b0, 1'b0);
        expect_byte(flen[15:8], 1'b0, 1'b0);
        expect_byte(flen[7:0], 1'b0, 1'b0);
      end else begin
        wide_len = 64'(flen);
        expect_byte(wsf_pkg::LEN64_CODE, 1'b0, 1'b0);
        for (int s = 7; s >= 0; s--) expect_byte(wide_len[8*s +: 8], 1'b0, 1'b0);
      end
      frame_left = flen;
    end
    frame_left = frame_left - 32'd1;
    next_off = msg_offset + 32'd1;
    eom = (next_off >= len) || (msg_offset >= len);
    expect_byte(req.payload_byte, 1'b1, eom);
    if (eom) begin
      msg_offset = '0;
      frame_left = '0;
      first_frame = 1'b1;
    end else begin
      msg_offset = next_off;
      if (frame_left == '0) first_frame = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : monitor
    wsf_pkg::out_item_t want;
    in_taken <= in_valid && in_ready && !rst;
    cfg_taken <= cfg_valid && cfg_ready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) chunk_bytes = cfg_data;
      if (in_valid && in_ready) begin
        frame_request(in_data);
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte %02h arrived with nothing expected", out_data.out_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            mismatches++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run,
                   out_data.last_of_run);
            mismatches++;
          end
          if (out_data.end_of_message !== want.end_of_message) begin
            $error("end_of_message: expected %b, got %b", want.end_of_message,
                   out_data.end_of_message);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_request(logic [7:0] b, logic [31:0] len);
    wsf_pkg::in_item_t r;
    r.payload_byte = b;
    r.message_length = len;
    pending_requests.push_back(r);
    requests_sent++;
  endtask

  task automatic queue_message(int len);
    for (int i = 0; i < len; i++) queue_request(8'($urandom_range(255)), len);
  endtask

  // Waits until every request is taken and every byte has come out, then
  // leaves room for a zero-length request still in flight.
  task automatic wait_idle();
    while (requests_taken != requests_sent || expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_chunk(logic [31:0] value);
    wait_idle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Mostly whole messages; the rest are empty requests, messages whose length
  // shrinks or grows partway, and huge lengths cut short on the next byte.
  task automatic queue_random_traffic(int target);
    int counted;
    int pick;
    int len;
    int k;
    int extra;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        len = $urandom_range(1, 14);
        queue_message(len);
        counted += len;
      end else if (pick < 78) begin
        queue_request(8'($urandom_range(255)), '0);
      end else if (pick < 87) begin
        k = $urandom_range(1, 6);
        len = k + $urandom_range(1, 20);
        repeat (k) queue_request(8'($urandom_range(255)), len);
        queue_request(8'($urandom_range(255)), $urandom_range(1, k));
        counted += k + 1;
      end else if (pick < 95) begin
        len = $urandom_range(2, 8);
        k = $urandom_range(1, len - 1);
        extra = $urandom_range(1, 8);
        repeat (k) queue_request(8'($urandom_range(255)), len);
        repeat (len + extra - k) queue_request(8'($urandom_range(255)), len + extra);
        counted += len + extra;
      end else begin
        queue_request(8'($urandom_range(255)), $urandom());
        queue_request(8'($urandom_range(255)), 32'd1);
        counted += 2;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default chunk size: empty requests, short messages, a gap inside a
    // message, and a length that drops to the offset mid-frame.
    queue_request(8'hFF, '0);
    queue_request(8'h00, 32'd1);
    queue_request(8'hFF, 32'd3);
    queue_request(8'hAA, 32'd3);
    queue_request(8'h55, 32'd3);
    queue_request(8'h0F, 32'd2);
    queue_request(8'hF0, '0);
    queue_request(8'h3C, 32'd2);
    queue_request(8'h5A, 32'd300);
    queue_request(8'hA5, 32'd1);

    // Sixteen-bit and sixty-four-bit length headers.
    set_chunk(32'd126);
    queue_request(8'h81, 32'd300);
    queue_request(8'h7E, 32'd2);
    set_chunk(32'd65536);
    queue_request(8'hC3, 32'd100000);
    queue_request(8'h24, 32'd1);
    set_chunk(32'hFFFF_FFFF);
    queue_request(8'h99, 32'hFFFF_FFFF);
    queue_request(8'h66, 32'd1);

    // A zero chunk size behaves as one byte per frame.
    set_chunk('0);
    queue_message(3);

    // The length shrinks right where a new frame opens.
    set_chunk(32'd1);
    queue_request(8'h12, 32'd5);
    queue_request(8'h34, 32'd1);

    // The length grows after the final frame was declared.
    set_chunk(32'd3);
    queue_request(8'h01, 32'd3);
    queue_request(8'h02, 32'd3);
    queue_request(8'h03, 32'd5);
    queue_request(8'h04, 32'd5);
    queue_request(8'h05, 32'd5);

    queue_random_traffic(12);
    wait_idle();
    queue_random_traffic(12);

    set_chunk($urandom_range(1, 8));
    send_idle = 61;
    recv_idle = 12;
    queue_random_traffic(25);

    set_chunk($urandom_range(2, 16));
    send_idle = 0;
    recv_idle = 0;
    queue_random_traffic(25);
    wait_idle();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
